/* rtl/tag_pkg.sv */
// Shared constants for the tacho average gauge target block.
`timescale 1ns / 1ps
package tag_pkg;

	localparam int DATA_W            = 16;
	localparam int PROD_W            = 2 * DATA_W;
	localparam int CFG_IDX_W         = 2;
	localparam int MUL_CNT_W         = $clog2(DATA_W + 1);
	localparam int DIV_CNT_W         = $clog2(PROD_W + 1);

	localparam int DEFAULT_AVG_DEPTH = 8;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_STEPS  = 2'd0,
		REG_FULL_SCALE = 2'd1,
		REG_OVSP_LIMIT = 2'd2,
		REG_BAD_THRESH = 2'd3
	} reg_idx_t;

	localparam logic [DATA_W-1:0] TARGET_DEADBAND = 16'd20;
	localparam logic [DATA_W-1:0] SHOW_HYST       = 16'd10;
	localparam logic [DATA_W-1:0] WARN_RELEASE    = 16'd300;
	localparam logic [DATA_W-1:0] OVERRIDE_MARK   = 16'hFFFF;

	localparam logic [DATA_W-1:0] RST_MAX_STEPS   = 16'd0;
	localparam logic [DATA_W-1:0] RST_FULL_SCALE  = 16'd65535;
	localparam logic [DATA_W-1:0] RST_OVSP_LIMIT  = 16'd0;
	localparam logic [DATA_W-1:0] RST_BAD_THRESH  = 16'd64256;

endpackage

/* rtl/tacho_average_gauge_target.sv */
// Top level: speed averaging ring, serial gauge target math, deadband and hysteresis.
//
//  channel   direction  handshake            payload
//  in        sink       in_valid / in_stall  io_override, timed_out, data_ready, raw_speed
//  out       source     out_valid / out_stall target_update, target_steps, average_speed,
//                                            shown_speed, overspeed_warning
//  cfg       sink       cfg_wr_en            cfg_index, cfg_data
//
// An item that stores no sample (override, or no fresh data) goes from idle
// straight to the last step. An item that stores a sample runs the serial
// divider twice (SUM_W = 16 + log2 depth bits for the average, 32 bits for the
// target) and the serial multiplier over 16 bits.
// One item is in work at a time; in_stall is high from acceptance to hand-off.
// The result register holds a finished item while out_stall is high; the next
// item is already taken and waits in its last step until the register frees.
// Reset is asynchronous; ring entries carry valid bits, so no clearing pass.
`timescale 1ns / 1ps
module tacho_average_gauge_target #(
	parameter int AVG_DEPTH = tag_pkg::DEFAULT_AVG_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              io_override,
	input  logic                              timed_out,
	input  logic                              data_ready,
	input  logic [tag_pkg::DATA_W-1:0]        raw_speed,

	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              target_update,
	output logic [tag_pkg::DATA_W-1:0]        target_steps,
	output logic [tag_pkg::DATA_W-1:0]        average_speed,
	output logic [tag_pkg::DATA_W-1:0]        shown_speed,
	output logic                              overspeed_warning,

	input  logic                              cfg_wr_en,
	input  logic [tag_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tag_pkg::DATA_W-1:0]        cfg_data
);
	import tag_pkg::*;

	localparam int SUM_W = DATA_W + $clog2(AVG_DEPTH);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_WR,
		ST_AVG_GO,
		ST_AVG_WAIT,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	function automatic logic [DATA_W-1:0] abs_diff(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	// configuration
	logic [DATA_W-1:0] max_steps_q;
	logic [DATA_W-1:0] full_scale_q;
	logic [DATA_W-1:0] ovsp_limit_q;
	logic [DATA_W-1:0] bad_thresh_q;

	// sequencer and tick state
	state_t            state_q;
	logic [DATA_W-1:0] sample_q;
	logic [DATA_W-1:0] avg_q;
	logic [DATA_W-1:0] last_target_q;
	logic [DATA_W-1:0] held_q;
	logic              warn_q;
	logic              upd_q;
	logic [DATA_W-1:0] issued_q;

	// result register
	logic              out_valid_q;
	logic              out_upd_q;
	logic [DATA_W-1:0] out_steps_q;
	logic [DATA_W-1:0] out_avg_q;
	logic [DATA_W-1:0] out_shown_q;
	logic              out_warn_q;

	// unit hookup
	logic [SUM_W-1:0]     ring_sum;
	logic                 mul_done;
	logic [PROD_W-1:0]    mul_prod;
	logic                 div_start;
	logic [PROD_W-1:0]    div_dvd;
	logic [DATA_W-1:0]    div_dsr;
	logic [DIV_CNT_W-1:0] div_nbits;
	logic                 div_done;
	logic [PROD_W-1:0]    div_quot;

	// per-tick decode and end-of-tick checks
	logic              in_acc;
	logic              bad_sample;
	logic              out_free;
	logic [DATA_W-1:0] tgt;
	logic              tgt_move;
	logic [DATA_W-1:0] held_nxt;
	logic              warn_nxt;

	assign in_acc     = in_valid && !in_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign bad_sample = timed_out || (raw_speed >= bad_thresh_q);
	assign out_free   = !out_valid_q || !out_stall;

	// divider shared: average first (constant divisor), then the target
	assign div_start = (state_q == ST_AVG_GO) || (state_q == ST_DIV_GO);
	always_comb begin
		if (state_q == ST_AVG_GO) begin
			div_dvd   = {ring_sum, {(PROD_W - SUM_W){1'b0}}};
			div_dsr   = DATA_W'(AVG_DEPTH);
			div_nbits = DIV_CNT_W'(SUM_W);
		end else begin
			div_dvd   = mul_prod;
			div_dsr   = (full_scale_q == '0) ? DATA_W'(1) : full_scale_q;
			div_nbits = DIV_CNT_W'(PROD_W);
		end
	end

	// saturated target and deadband against the last one issued
	assign tgt      = (div_quot[PROD_W-1:DATA_W] != '0) ? OVERRIDE_MARK
	                                                    : div_quot[DATA_W-1:0];
	assign tgt_move = abs_diff(tgt, last_target_q) > TARGET_DEADBAND;

	// shown speed hysteresis and overspeed set/release on the current average
	assign held_nxt = (abs_diff(avg_q, held_q) > SHOW_HYST) ? avg_q : held_q;
	always_comb begin
		warn_nxt = warn_q;
		if (avg_q >= ovsp_limit_q) begin
			warn_nxt = 1'b1;
		end else if (ovsp_limit_q >= WARN_RELEASE && avg_q <= ovsp_limit_q - WARN_RELEASE) begin
			warn_nxt = 1'b0;
		end
	end

	tag_ring #(
		.DEPTH (AVG_DEPTH)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (state_q == ST_RD),
		.wr_en   (state_q == ST_WR),
		.wr_data (sample_q),
		.sum     (ring_sum)
	);

	tag_smul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_MUL_GO),
		.mcand  (max_steps_q),
		.mplier (avg_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	tag_sdiv u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.nbits    (div_nbits),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_steps_q  <= RST_MAX_STEPS;
			full_scale_q <= RST_FULL_SCALE;
			ovsp_limit_q <= RST_OVSP_LIMIT;
			bad_thresh_q <= RST_BAD_THRESH;
		end else if (cfg_wr_en) begin
			unique case (reg_idx_t'(cfg_index))
				REG_MAX_STEPS:  max_steps_q  <= cfg_data;
				REG_FULL_SCALE: full_scale_q <= cfg_data;
				REG_OVSP_LIMIT: ovsp_limit_q <= cfg_data;
				REG_BAD_THRESH: bad_thresh_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			sample_q      <= '0;
			avg_q         <= '0;
			last_target_q <= '0;
			held_q        <= '0;
			warn_q        <= 1'b0;
			upd_q         <= 1'b0;
			issued_q      <= '0;
			out_valid_q   <= 1'b0;
			out_upd_q     <= 1'b0;
			out_steps_q   <= '0;
			out_avg_q     <= '0;
			out_shown_q   <= '0;
			out_warn_q    <= 1'b0;
		end else begin
			// load on hand-off, clear once the result is taken
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						upd_q    <= 1'b0;
						issued_q <= '0;
						sample_q <= bad_sample ? '0 : raw_speed;
						if (io_override) begin
							last_target_q <= OVERRIDE_MARK;
							state_q       <= ST_FINISH;
						end else if (bad_sample || data_ready) begin
							state_q <= ST_RD;
						end else begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_RD:       state_q <= ST_WR;
				ST_WR:       state_q <= ST_AVG_GO;
				ST_AVG_GO:   state_q <= ST_AVG_WAIT;
				ST_AVG_WAIT: begin
					if (div_done) begin
						avg_q   <= div_quot[DATA_W-1:0];
						state_q <= ST_MUL_GO;
					end
				end
				ST_MUL_GO:   state_q <= ST_MUL_WAIT;
				ST_MUL_WAIT: begin
					if (mul_done) begin
						state_q <= ST_DIV_GO;
					end
				end
				ST_DIV_GO:   state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						if (tgt_move) begin
							last_target_q <= tgt;
							upd_q         <= 1'b1;
							issued_q      <= tgt;
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						held_q      <= held_nxt;
						warn_q      <= warn_nxt;
						out_upd_q   <= upd_q;
						out_steps_q <= issued_q;
						out_avg_q   <= avg_q;
						out_shown_q <= held_nxt;
						out_warn_q  <= warn_nxt;
						state_q     <= ST_IDLE;
					end
				end
				default:     state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign target_update     = out_upd_q;
	assign target_steps      = out_steps_q;
	assign average_speed     = out_avg_q;
	assign shown_speed       = out_shown_q;
	assign overspeed_warning = out_warn_q;

endmodule

/* rtl/tag_ring.sv */
// Sample ring memory with valid bits, write pointer and running sum.
`timescale 1ns / 1ps
module tag_ring #(
	parameter int DEPTH = tag_pkg::DEFAULT_AVG_DEPTH
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      rd_en,
	input  logic                                      wr_en,
	input  logic [tag_pkg::DATA_W-1:0]                wr_data,
	output logic [tag_pkg::DATA_W+$clog2(DEPTH)-1:0]  sum
);
	import tag_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int SUM_W = DATA_W + IDX_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [IDX_W-1:0]  idx_q;
	logic [SUM_W-1:0]  sum_q;
	logic [DATA_W-1:0] rd_q;
	logic              old_vld_q;
	logic [DATA_W-1:0] old_val;

	// never-written entries count as zero
	assign old_val = old_vld_q ? rd_q : '0;
	assign sum     = sum_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[idx_q];
		end
		if (wr_en) begin
			mem[idx_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			idx_q     <= '0;
			sum_q     <= '0;
			old_vld_q <= 1'b0;
		end else begin
			if (rd_en) begin
				old_vld_q <= vld_q[idx_q];
			end
			if (wr_en) begin
				sum_q        <= sum_q - SUM_W'(old_val) + SUM_W'(wr_data);
				vld_q[idx_q] <= 1'b1;
				if (idx_q == IDX_W'(DEPTH - 1)) begin
					idx_q <= '0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/tag_smul.sv */
// Bit-serial 16x16 shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
module tag_smul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tag_pkg::DATA_W-1:0]   mcand,
	input  logic [tag_pkg::DATA_W-1:0]   mplier,
	output logic                         done,
	output logic [tag_pkg::PROD_W-1:0]   prod
);
	import tag_pkg::*;

	logic [DATA_W-1:0]    mcand_q;
	logic [DATA_W-1:0]    hi_q;
	logic [DATA_W-1:0]    lo_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DATA_W:0]      psum;

	assign psum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
	assign prod = {hi_q, lo_q};
	assign done = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= mcand;
			hi_q    <= '0;
			lo_q    <= mplier;
		end else if (cnt_q != '0) begin
			hi_q <= psum[DATA_W:1];
			lo_q <= {psum[0], lo_q[DATA_W-1:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= MUL_CNT_W'(DATA_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == MUL_CNT_W'(1));
			end
		end
	end

endmodule

/* rtl/tag_sdiv.sv */
// Bit-serial restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module tag_sdiv (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [tag_pkg::PROD_W-1:0]     dividend,
	input  logic [tag_pkg::DATA_W-1:0]     divisor,
	input  logic [tag_pkg::DIV_CNT_W-1:0]  nbits,
	output logic                           done,
	output logic [tag_pkg::PROD_W-1:0]     quot
);
	import tag_pkg::*;

	// dividend is left aligned; nbits quotient bits land in the low end of quot
	logic [PROD_W-1:0]    dvd_q;
	logic [DATA_W-1:0]    dsr_q;
	logic [DATA_W-1:0]    rem_q;
	logic [PROD_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DATA_W:0]      trial;
	logic [DATA_W:0]      diff;
	logic                 ge;

	assign trial = {rem_q, dvd_q[PROD_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};
	assign quot  = quo_q;
	assign done  = done_q;

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[PROD_W-2:0], 1'b0};
			rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= nbits;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == DIV_CNT_W'(1));
			end
		end
	end

endmodule

/* rtl/tag_chk.sv */
// Port-level checker for the tacho average gauge target, bound to the top level.
`timescale 1ns / 1ps
module tag_chk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       target_update,
	input  logic [tag_pkg::DATA_W-1:0] target_steps,
	input  logic [tag_pkg::DATA_W-1:0] average_speed,
	input  logic [tag_pkg::DATA_W-1:0] shown_speed,
	input  logic                       overspeed_warning
);
	import tag_pkg::*;

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item was in work");

	// a new result only comes out of an item in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in work");

	// no issued target means zero steps
	a_steps_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !target_update |-> target_steps == '0)
		else $error("target steps nonzero without an update");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(target_update)
			&& $stable(target_steps) && $stable(average_speed)
			&& $stable(shown_speed) && $stable(overspeed_warning))
		else $error("stalled result changed");

endmodule

bind tacho_average_gauge_target tag_chk u_tag_chk (.*);
